// File: sv/token_expiry_table_macros.svh
// ----------------------------------------------------------------------------
// Token expiry table assertion macros
// Shared forms for the concurrent checks on the table's ports.
// ----------------------------------------------------------------------------
`ifndef TOKEN_EXPIRY_TABLE_MACROS_SVH
`define TOKEN_EXPIRY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tet_pkg.sv
// ----------------------------------------------------------------------------
// Token expiry table package
// Shared widths, defaults, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package tet_pkg;

  // Default sizing of the table
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int EXP_W   = 33;
  localparam int COUNT_W = 5;

  localparam logic [TIME_W-1:0]  TTL_RESET = 32'd5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Operation codes carried on the mode field
  typedef enum logic [1:0] {
    MODE_GEN   = 2'd0,
    MODE_RENEW = 2'd1,
    MODE_COUNT = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_SCAN   = 2'd2,
    ST_COMMIT = 2'd3
  } state_t;

endpackage

// File: sv/token_expiry_table.sv
// ----------------------------------------------------------------------------
// Token expiry table
// Fixed table of keyed tokens with expiry times: generate, renew and count.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_mode, in_token_key, in_current_time
//   out_      output     out_valid/out_ready  out_live_count, out_applied, out_table_full
//   cfg_      input      cfg_wr_en            cfg_wr_data (time to live)
//
// Each item is taken in idle; the table RAM is then scanned one entry per
// cycle through its single read port, each read registered before it is
// evaluated, and a commit state makes the final write before ready returns.
// After reset a clearing pass writes every entry empty in turn; no input is
// taken meanwhile, configuration writes are taken as always.
// A stalled result holds in the output register; the commit waits until it
// is taken.
// ----------------------------------------------------------------------------
module token_expiry_table import tet_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_token_key,
  input  logic [TIME_W-1:0]  in_current_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] out_live_count,
  output logic               out_applied,
  output logic               out_table_full,
  input  logic               cfg_wr_en,
  input  logic [TIME_W-1:0]  cfg_wr_data
);

  localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WORD_W = 1 + KEY_W + EXP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Control registers
  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   ttl_r, ttl_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                eval_vld_r, eval_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Operation and scan registers
  mode_t               mode_r, mode_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [EXP_W-1:0]    fresh_r, fresh_nxt;
  logic [IDX_W-1:0]    eval_idx_r, eval_idx_nxt;
  logic                hit_found_r, hit_found_nxt;
  logic                hit_live_r, hit_live_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [COUNT_W-1:0]  live_cnt_r, live_cnt_nxt;
  logic [COUNT_W-1:0]  out_live_count_r, out_live_count_nxt;
  logic                out_applied_r, out_applied_nxt;
  logic                out_table_full_r, out_table_full_nxt;

  // RAM port signals
  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [WORD_W-1:0]   ram_wr_data;
  logic                ram_rd_en;
  logic [WORD_W-1:0]   ram_rd_data;

  // Entry decode and shared compare unit
  logic                ent_valid;
  logic [KEY_W-1:0]    ent_key;
  logic [EXP_W-1:0]    ent_exp;
  logic                ent_live;
  logic                ent_hit;
  logic                ent_free;
  logic                accept;
  logic                scan_last;
  logic                commit_fire;
  logic                commit_ok;
  logic [IDX_W-1:0]    commit_idx;

  tet_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  // Split the entry read back and compare it against the operation
  assign ent_valid = ram_rd_data[WORD_W-1];
  assign ent_key   = ram_rd_data[EXP_W +: KEY_W];
  assign ent_exp   = ram_rd_data[EXP_W-1:0];
  assign ent_live  = ent_valid && (ent_exp > {1'b0, now_r});
  assign ent_hit   = ent_valid && (ent_key == key_r);
  assign ent_free  = !ent_live;

  assign accept      = in_valid && in_ready;
  assign scan_last   = eval_vld_r && (eval_idx_r == LAST_IDX);
  assign commit_fire = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);

  // Pick the slot and outcome of the final write
  always_comb begin
    commit_ok  = 1'b0;
    commit_idx = hit_idx_r;
    case (mode_r)
      MODE_GEN: begin
        commit_ok  = hit_found_r || free_found_r;
        commit_idx = hit_found_r ? hit_idx_r : free_idx_r;
      end
      MODE_RENEW: begin
        commit_ok  = hit_found_r && hit_live_r;
        commit_idx = hit_idx_r;
      end
      default: begin
        commit_ok  = 1'b0;
        commit_idx = hit_idx_r;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshake and RAM control
  always_comb begin
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        ram_rd_en   = !issue_done_r;
        // drop expired entries during a count
        ram_wr_en   = eval_vld_r && (mode_r == MODE_COUNT) && ent_valid && !ent_live;
        ram_wr_addr = eval_idx_r;
        ram_wr_data = {1'b0, ent_key, ent_exp};
      end
      ST_COMMIT: begin
        ram_wr_en   = commit_fire && commit_ok;
        ram_wr_addr = commit_idx;
        ram_wr_data = {1'b1, key_r, fresh_r};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    ttl_nxt            = cfg_wr_en ? cfg_wr_data : ttl_r;
    idx_nxt            = idx_r;
    issue_done_nxt     = issue_done_r;
    eval_vld_nxt       = 1'b0;
    eval_idx_nxt       = idx_r;
    mode_nxt           = mode_r;
    key_nxt            = key_r;
    now_nxt            = now_r;
    fresh_nxt          = fresh_r;
    hit_found_nxt      = hit_found_r;
    hit_live_nxt       = hit_live_r;
    hit_idx_nxt        = hit_idx_r;
    free_found_nxt     = free_found_r;
    free_idx_nxt       = free_idx_r;
    live_cnt_nxt       = live_cnt_r;
    out_live_count_nxt = out_live_count_r;
    out_applied_nxt    = out_applied_r;
    out_table_full_nxt = out_table_full_r;
    out_valid_nxt      = out_valid_r && !out_ready;

    case (state_r)
      ST_CLEAR: begin
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        // latch the operation and start the scan
        if (accept) begin
          mode_nxt       = mode_t'(in_mode);
          key_nxt        = in_token_key[KEY_W-1:0];
          now_nxt        = in_current_time;
          fresh_nxt      = {1'b0, in_current_time} + {1'b0, ttl_r};
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          hit_found_nxt  = 1'b0;
          hit_live_nxt   = 1'b0;
          free_found_nxt = 1'b0;
          live_cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        // advance the read address
        if (ram_rd_en) begin
          idx_nxt        = (idx_r == LAST_IDX) ? idx_r : idx_r + 1'b1;
          issue_done_nxt = (idx_r == LAST_IDX);
        end
        eval_vld_nxt = ram_rd_en;
        eval_idx_nxt = idx_r;
        // evaluate the entry that came back
        if (eval_vld_r) begin
          if (ent_hit && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_live_nxt  = ent_live;
            hit_idx_nxt   = eval_idx_r;
          end
          if (ent_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = eval_idx_r;
          end
          if (ent_live && (live_cnt_r != COUNT_MAX)) begin
            live_cnt_nxt = live_cnt_r + 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        // load the result register
        if (commit_fire) begin
          out_valid_nxt      = 1'b1;
          out_live_count_nxt = (mode_r == MODE_COUNT) ? live_cnt_r : '0;
          out_applied_nxt    = commit_ok;
          out_table_full_nxt = (mode_r == MODE_GEN) && !commit_ok;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      ttl_r        <= TTL_RESET;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      eval_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ttl_r        <= ttl_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      eval_vld_r   <= eval_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r           <= mode_nxt;
    key_r            <= key_nxt;
    now_r            <= now_nxt;
    fresh_r          <= fresh_nxt;
    eval_idx_r       <= eval_idx_nxt;
    hit_found_r      <= hit_found_nxt;
    hit_live_r       <= hit_live_nxt;
    hit_idx_r        <= hit_idx_nxt;
    free_found_r     <= free_found_nxt;
    free_idx_r       <= free_idx_nxt;
    live_cnt_r       <= live_cnt_nxt;
    out_live_count_r <= out_live_count_nxt;
    out_applied_r    <= out_applied_nxt;
    out_table_full_r <= out_table_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_live_count = out_live_count_r;
  assign out_applied    = out_applied_r;
  assign out_table_full = out_table_full_r;

endmodule

// File: sv/tet_ram.sv
// ----------------------------------------------------------------------------
// Token expiry table RAM
// Generic simple dual-port memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/tet_chk.sv
// ----------------------------------------------------------------------------
// Token expiry table checker
// Port-level checks on the table's transfers and result fields.
// ----------------------------------------------------------------------------
`include "token_expiry_table_macros.svh"

module tet_chk import tet_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_live_count,
  input logic               out_applied,
  input logic               out_table_full
);

  // Hold the result while the consumer stalls
  `TET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_live_count) && $stable(out_applied) && $stable(out_table_full), "result changed while stalled")

  // Stop taking items once one is in work
  `TET_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready stayed high after an input transfer")

  // Flag a store and a full table never together
  `TET_ASSERT_NOW(a_flags_excl, out_valid, !(out_applied && out_table_full), "applied and table_full both set")

  // Report a count only with both flags clear
  `TET_ASSERT_NOW(a_count_alone, out_valid && (out_live_count != '0), !out_applied && !out_table_full, "count result carries a flag")

endmodule

bind token_expiry_table tet_chk u_tet_chk (.*);
